// ----- hdl/barometric_pressure_compensation_top_assert.svh -----
// Assertion macros used by the barometric compensation RTL
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH

// implication checked on every edge outside reset
`define BPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bpc_pkg.sv -----
package bpc_pkg;

  localparam int unsigned DivBits = 32;

  typedef enum logic [2:0] {
    REG_AC1   = 3'd0,
    REG_AC2   = 3'd1,
    REG_AC3   = 3'd2,
    REG_AC4   = 3'd3,
    REG_TEMP  = 3'd4,
    REG_QUAD  = 3'd5,
    REG_CORR  = 3'd6,
    REG_OSS   = 3'd7
  } reg_idx_t;

  // payload carried through the divider lanes besides the division itself
  typedef struct packed {
    logic [31:0] aux_a;
    logic [31:0] aux_b;
    logic [1:0]  oss;
    logic        neg;
    logic        post_dbl;
    logic        fault;
  } bpc_side_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
    asr32 = 32'($signed(v) >>> n);
  endfunction

endpackage

// ----- hdl/barometric_pressure_compensation_top.sv -----
// Barometric pressure compensation, integer data-sheet algorithm.
// Input channel: in_valid/in_stall with temp_word and press_word.
// Output channel: out_valid/out_stall with pressure_pa and div_fault.
// Configuration: cfg_we writes cfg_data into register cfg_index (0..7);
// write only while the pipeline is empty.
// One transaction may enter every cycle; the whole pipeline advances
// together, so throughput is one item per cycle while out_stall is low.
// From input accept to result the path runs through two 32-stage
// one-bit-per-stage dividers plus twelve arithmetic stages.
// A zero divisor gives pressure_pa 0 with div_fault 1.
// While out_stall is high with a result waiting, every stage holds and
// in_stall rises; nothing is dropped or repeated. Empty stages hold as
// well, so bubbles are not squeezed out during a stall.
// Reset clears all valid bits and all coefficient registers to zero.
module barometric_pressure_compensation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] temp_word,
  input  logic [18:0] press_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pressure_pa,
  output logic        div_fault,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import bpc_pkg::*;
  `include "barometric_pressure_compensation_top_assert.svh"

  logic [15:0] ac1, ac2, ac3, ac4;
  logic [31:0] tcp, qcp, ccp;
  logic [1:0]  oss_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1 <= '0; ac2 <= '0; ac3 <= '0; ac4 <= '0;
      tcp <= '0; qcp <= '0; ccp <= '0; oss_reg <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_AC1:  ac1 <= cfg_data[15:0];
        REG_AC2:  ac2 <= cfg_data[15:0];
        REG_AC3:  ac3 <= cfg_data[15:0];
        REG_AC4:  ac4 <= cfg_data[15:0];
        REG_TEMP: tcp <= cfg_data;
        REG_QUAD: qcp <= cfg_data;
        REG_CORR: ccp <= cfg_data;
        REG_OSS:  oss_reg <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] s_ac1, s_ac2, s_ac3, u_ac4, u_ac5, u_ac6, s_b1, s_b2, s_mc, s_md;
  assign s_ac1 = 32'($signed(ac1));
  assign s_ac2 = 32'($signed(ac2));
  assign s_ac3 = 32'($signed(ac3));
  assign u_ac4 = {16'd0, ac4};
  assign u_ac5 = {16'd0, tcp[31:16]};
  assign u_ac6 = {16'd0, tcp[15:0]};
  assign s_b1  = 32'($signed(qcp[31:16]));
  assign s_b2  = 32'($signed(qcp[15:0]));
  assign s_mc  = 32'($signed(ccp[31:16]));
  assign s_md  = 32'($signed(ccp[15:0]));

  // one global advance: hold everything while the output is stalled
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage a1: ut - ac6
  logic        a1_v; logic [31:0] a1_d; logic [18:0] a1_up;
  // stage a2: product with ac5
  logic        a2_v; logic [31:0] a2_p; logic [18:0] a2_up;
  // stage a3: x1, den, numerator, signs
  logic        a3_v; logic [31:0] a3_x1, a3_na, a3_da; logic [18:0] a3_up;
  logic        a3_neg, a3_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      a1_v <= 1'b0; a2_v <= 1'b0; a3_v <= 1'b0;
    end else if (adv) begin
      a1_v <= in_valid; a2_v <= a1_v; a3_v <= a2_v;
    end
    if (adv) begin
      a1_d  <= {16'd0, temp_word} - u_ac6;
      a1_up <= press_word;
      a2_p  <= a1_d * u_ac5;
      a2_up <= a1_up;
    end
  end

  logic [31:0] x1c, denc, numc;
  always_comb begin
    x1c  = asr32(a2_p, 5'd15);
    denc = x1c + s_md;
    numc = s_mc << 11;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a3_x1  <= x1c;
      a3_up  <= a2_up;
      a3_z   <= (denc == 32'd0);
      a3_neg <= numc[31] ^ denc[31];
      a3_na  <= numc[31] ? 32'd0 - numc : numc;
      a3_da  <= (denc == 32'd0) ? 32'd1 : (denc[31] ? 32'd0 - denc : denc);
    end
  end

  bpc_side_t d1_in, d1_out;
  logic      d1_v;
  logic [31:0] d1_q;
  always_comb begin
    d1_in          = '0;
    d1_in.aux_a    = a3_x1;
    d1_in.aux_b    = {13'd0, a3_up};
    d1_in.oss      = oss_reg;
    d1_in.neg      = a3_neg;
    d1_in.fault    = a3_z;
  end

  bpc_div u_div_t (
    .clk, .rst, .adv,
    .in_vld(a3_v), .in_num(a3_na), .in_den(a3_da), .in_side(d1_in),
    .out_vld(d1_v), .out_quo(d1_q), .out_side(d1_out)
  );

  // stage b1: b6
  logic b1_v; logic [31:0] b1_b6; bpc_side_t b1_s;
  // stage b2: b6 squared, ac2*b6, ac3*b6
  logic b2_v; logic [31:0] b2_sq, b2_t2, b2_t3; bpc_side_t b2_s;
  // stage b3: sq shifted, products with b2/b1
  logic b3_v; logic [31:0] b3_p2, b3_p1, b3_t2, b3_t3; bpc_side_t b3_s;
  // stage b4: b3, x3 for b4
  logic b4_v; logic [31:0] b4_b3, b4_x3; bpc_side_t b4_s;
  // stage b5: b4 product, up - b3
  logic b5_v; logic [31:0] b5_b4p, b5_d; bpc_side_t b5_s;
  // stage b6: b7, b4
  logic b6_v; logic [31:0] b6_b7, b6_b4; bpc_side_t b6_s;

  logic [31:0] x2q, sqc, x3a, x3b, b3c, b4c, b7c;
  logic [31:0] b7k;
  bpc_side_t   b5_sf;
  always_comb begin
    x2q = d1_out.neg ? 32'd0 - d1_q : d1_q;
    sqc = asr32(b2_sq, 5'd12);
    x3a = asr32(b3_p2 + b3_t2, 5'd11);
    b3c = asr32(((s_ac1 << 2) + x3a) << b3_s.oss, 5'd0);
    b3c = asr32(b3c + 32'd2, 5'd2);
    x3b = asr32(asr32(b3_t3, 5'd13) + asr32(b3_p1, 5'd16) + 32'd2, 5'd2);
    b4c = b5_b4p >> 15;
    b7k = 32'd50000 >> b5_s.oss;
    b7c = b5_d * b7k;
    b5_sf       = b5_s;
    b5_sf.fault = b5_s.fault || (b4c == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0; b2_v <= 1'b0; b3_v <= 1'b0;
      b4_v <= 1'b0; b5_v <= 1'b0; b6_v <= 1'b0;
    end else if (adv) begin
      b1_v <= d1_v; b2_v <= b1_v; b3_v <= b2_v;
      b4_v <= b3_v; b5_v <= b4_v; b6_v <= b5_v;
    end
    if (adv) begin
      b1_b6 <= d1_out.aux_a + x2q - 32'd4000;
      b1_s  <= d1_out;
      b2_sq <= b1_b6 * b1_b6;
      b2_t2 <= s_ac2 * b1_b6;
      b2_t3 <= s_ac3 * b1_b6;
      b2_s  <= b1_s;
      b3_p2 <= s_b2 * sqc;
      b3_p1 <= s_b1 * sqc;
      b3_t2 <= b2_t2;
      b3_t3 <= b2_t3;
      b3_s  <= b2_s;
      b4_b3 <= b3c;
      b4_x3 <= x3b;
      b4_s  <= b3_s;
      b5_b4p <= u_ac4 * (b4_x3 + 32'd32768);
      b5_d   <= b4_s.aux_b - b4_b3;
      b5_s   <= b4_s;
      b6_b7  <= b7c;
      b6_b4  <= b4c;
      b6_s   <= b5_sf;
    end
  end

  bpc_side_t d2_in, d2_out;
  logic      d2_v;
  logic [31:0] d2_q;
  always_comb begin
    d2_in          = b6_s;
    d2_in.post_dbl = b6_b7[31];
  end

  bpc_div u_div_p (
    .clk, .rst, .adv,
    .in_vld(b6_v),
    .in_num(b6_b7[31] ? b6_b7 : b6_b7 << 1),
    .in_den(b6_b4 == 32'd0 ? 32'd1 : b6_b4),
    .in_side(d2_in),
    .out_vld(d2_v), .out_quo(d2_q), .out_side(d2_out)
  );

  // stage c1: p, p>>8 squared, -7357*p
  logic c1_v; logic [31:0] c1_p, c1_sq, c1_m; logic c1_f;
  // stage c2: x1 = sq*3038
  logic c2_v; logic [31:0] c2_p, c2_x1, c2_m; logic c2_f;
  // stage c3: final sum into output register
  logic [31:0] pc, p8;
  always_comb begin
    pc = d2_out.post_dbl ? d2_q << 1 : d2_q;
    p8 = asr32(pc, 5'd8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0; c2_v <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      c1_v <= d2_v; c2_v <= c1_v; out_valid <= c2_v;
    end
    if (adv) begin
      c1_p  <= pc;
      c1_sq <= p8 * p8;
      c1_m  <= (32'd0 - 32'd7357) * pc;
      c1_f  <= d2_out.fault;
      c2_p  <= c1_p;
      c2_x1 <= c1_sq * 32'd3038;
      c2_m  <= c1_m;
      c2_f  <= c1_f;
      div_fault   <= c2_f;
      pressure_pa <= c2_f ? 32'd0 :
        c2_p + asr32(asr32(c2_x1, 5'd16) + asr32(c2_m, 5'd16) + 32'd3791, 5'd4);
    end
  end

  `BPC_ASSERT_IMP(a_fault_zero, out_valid && div_fault, pressure_pa == 32'd0,
                  "fault result must carry zero pressure")
  `BPC_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(pressure_pa),
                   "stalled result changed")
  `BPC_ASSERT_IMP(a_stall_link, out_valid && out_stall, in_stall,
                  "input accepted while output stalled")
endmodule

// ----- hdl/bpc_div.sv -----
// Fully pipelined unsigned 32 by 32 divider, one quotient bit per stage.
module bpc_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [31:0]         in_num,
  input  logic [31:0]         in_den,
  input  bpc_pkg::bpc_side_t  in_side,
  output logic                out_vld,
  output logic [31:0]         out_quo,
  output bpc_pkg::bpc_side_t  out_side
);
  import bpc_pkg::*;

  logic               vld  [1:DivBits];
  logic [31:0]        rem  [1:DivBits];
  logic [31:0]        num  [1:DivBits];
  logic [31:0]        den  [1:DivBits];
  bpc_side_t          side [1:DivBits];

  for (genvar s = 0; s < DivBits; s++) begin : g_stage
    logic        cur_vld;
    logic [31:0] cur_rem;
    logic [31:0] cur_num;
    logic [31:0] cur_den;
    bpc_side_t   cur_side;
    logic [32:0] trial;
    logic [32:0] diff;
    if (s == 0) begin : g_src
      assign cur_vld  = in_vld;
      assign cur_rem  = '0;
      assign cur_num  = in_num;
      assign cur_den  = in_den;
      assign cur_side = in_side;
    end else begin : g_src
      assign cur_vld  = vld[s];
      assign cur_rem  = rem[s];
      assign cur_num  = num[s];
      assign cur_den  = den[s];
      assign cur_side = side[s];
    end
    always_comb begin
      trial = {cur_rem, cur_num[31]};
      diff  = trial - {1'b0, cur_den};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= cur_vld;
      end
      if (adv) begin
        rem[s+1]  <= diff[32] ? trial[31:0] : diff[31:0];
        num[s+1]  <= {cur_num[30:0], ~diff[32]};
        den[s+1]  <= cur_den;
        side[s+1] <= cur_side;
      end
    end
  end

  assign out_vld  = vld[DivBits];
  assign out_quo  = num[DivBits];
  assign out_side = side[DivBits];
endmodule

// ----- sim/tb_barometric_pressure_compensation_top.sv -----
module tb_barometric_pressure_compensation_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  typedef struct {
    logic [15:0] temp;
    logic [18:0] press;
  } raw_sample_t;

  typedef struct {
    logic [31:0] pa;
    logic        fault;
  } pressure_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] temp_word = '0;
  logic [18:0] press_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] pressure_pa;
  logic        div_fault;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // calibration copy used for prediction
  logic [15:0] cal_ac1 = '0, cal_ac2 = '0, cal_ac3 = '0, cal_ac4 = '0;
  logic [31:0] cal_temp = '0, cal_quad = '0, cal_corr = '0;
  logic [1:0]  cal_oss = '0;

  raw_sample_t      sample_q[$];
  pressure_result_t pressure_q[$];
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  bit  quiet = 0;
  int  n_checked = 0;
  int  n_faults = 0;
  int  n_errors = 0;
  int  n_items = 0;
  int  n_phases = 0;

  barometric_pressure_compensation_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sra(input logic [31:0] v, input int n);
    return $signed(v) >>> n;
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // signed divide, truncating toward zero, wraps like 32-bit hardware
  function automatic logic [31:0] div_trunc(input logic [31:0] n, input logic [31:0] d);
    logic [31:0] na, da, q;
    na = n[31] ? -n : n;
    da = d[31] ? -d : d;
    q = na / da;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  function automatic pressure_result_t compensate(input logic [15:0] ut16,
                                                  input logic [18:0] up19);
    pressure_result_t r;
    logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, den, b6, sq, b3, b4, b7, p;
    ut = {16'd0, ut16};
    up = {13'd0, up19};
    ac1 = sext16(cal_ac1);
    ac2 = sext16(cal_ac2);
    ac3 = sext16(cal_ac3);
    ac4 = {16'd0, cal_ac4};
    ac5 = {16'd0, cal_temp[31:16]};
    ac6 = {16'd0, cal_temp[15:0]};
    b1 = sext16(cal_quad[31:16]);
    b2 = sext16(cal_quad[15:0]);
    mc = sext16(cal_corr[31:16]);
    md = sext16(cal_corr[15:0]);
    r.pa = '0;
    r.fault = 1'b1;
    x1 = sra((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = div_trunc(mc << 11, den);
    b6 = x1 + x2 - 32'd4000;
    sq = sra(b6 * b6, 12);
    x1 = b2 * sq;
    x2 = ac2 * b6;
    x3 = sra(x1 + x2, 11);
    b3 = sra(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * (32'd50000 >> cal_oss);
    if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = sra(p, 8);
    x1 = x1 * x1;
    x1 = sra(x1 * 32'd3038, 16);
    x2 = sra(32'hFFFF_E343 * p, 16);
    r.pa = p + sra(x1 + x2 + 32'd3791, 4);
    r.fault = 1'b0;
    return r;
  endfunction

  function automatic int pick_gap(input bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // source side
  always @(posedge clk) begin
    raw_sample_t s;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) pressure_q.push_back(compensate(temp_word, press_word));
      if (gap_left != 0 || sample_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        s = sample_q.pop_front();
        temp_word <= s.temp;
        press_word <= s.press;
        in_valid <= 1'b1;
        gap_left <= pick_gap(quiet);
      end
    end
  end

  // sink side
  always @(posedge clk) begin
    pressure_result_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pressure_q.size() == 0) begin
          $error("result with no transaction pending: pressure_pa=%0h", pressure_pa);
          n_errors++;
        end else begin
          e = pressure_q.pop_front();
          if (pressure_pa !== e.pa) begin
            $error("pressure_pa expected %0h actual %0h", e.pa, pressure_pa);
            n_errors++;
          end
          if (div_fault !== e.fault) begin
            $error("div_fault expected %0b actual %0b", e.fault, div_fault);
            n_errors++;
          end
          if (e.fault) n_faults++;
        end
        n_checked++;
      end
      // one long hold while many items are still waiting, to back up the input
      if (!hold_done && n_checked >= 50 && sample_q.size() > 60) begin
        hold_done <= 1;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left != 1);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left != 1);
      end else begin
        stall_left <= pick_gap(quiet);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || pressure_q.size() != 0 || in_valid);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_AC1:  cal_ac1 = val[15:0];
      REG_AC2:  cal_ac2 = val[15:0];
      REG_AC3:  cal_ac3 = val[15:0];
      REG_AC4:  cal_ac4 = val[15:0];
      REG_TEMP: cal_temp = val;
      REG_QUAD: cal_quad = val;
      REG_CORR: cal_corr = val;
      REG_OSS:  cal_oss = val[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_cal(input logic [31:0] ac1, ac2, ac3, ac4, tpair, qpair, cpair, oss);
    @(posedge clk);
    write_reg(REG_AC1, ac1);
    write_reg(REG_AC2, ac2);
    write_reg(REG_AC3, ac3);
    write_reg(REG_AC4, ac4);
    write_reg(REG_TEMP, tpair);
    write_reg(REG_QUAD, qpair);
    write_reg(REG_CORR, cpair);
    write_reg(REG_OSS, oss);
    cfg_we <= 1'b0;
    n_phases++;
  endtask

  // typical sensor calibration, oss selectable
  task automatic load_typical(input logic [1:0] oss);
    load_cal(32'd408, -32'sd72, -32'sd14383, 32'd32741, {16'd32757, 16'd23153},
             {16'd6190, 16'd4}, {16'hDDF9, 16'd2868}, {30'd0, oss});
  endtask

  task automatic add(input logic [15:0] t, input logic [18:0] p);
    raw_sample_t s;
    s.temp = t;
    s.press = p;
    sample_q.push_back(s);
    n_items++;
  endtask

  task automatic add_edges();
    add(16'd27898, 19'd23843);
    add(16'd0, 19'd0);
    add(16'hFFFF, 19'h7FFFF);
    add(16'd0, 19'h7FFFF);
    add(16'hFFFF, 19'd0);
  endtask

  task automatic random_phase(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        add(16'($urandom_range(20000, 40000)), 19'($urandom_range(0, 65535 << cal_oss)));
      else
        add(16'($urandom), 19'($urandom));
    end
    drain();
  endtask

  initial begin
    #3ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // reset calibration: both divisors zero
    add_edges();
    drain();
    for (int m = 0; m < 4; m++) begin
      load_typical(2'(m));
      add_edges();
      add(16'd32768, 19'd40000 << m);
      drain();
    end
    // zero temperature divisor, then zero pressure divisor
    load_cal(32'd408, 32'd0, 32'd0, 32'd32741, 32'd0, 32'd0, 32'd0, 32'd0);
    add_edges();
    drain();
    load_cal(32'd408, 32'd0, 32'd0, 32'd0, {16'd32757, 16'd23153}, 32'd0,
             {16'hDDF9, 16'd2868}, 32'd1);
    add_edges();
    drain();
    load_cal('1, '1, '1, '1, '1, '1, '1, '1);
    add_edges();
    drain();
    load_cal(32'h8000, 32'h7FFF, 32'h8000, 32'hFFFF, 32'hFFFF_0000, 32'h8000_7FFF,
             32'h7FFF_8000, 32'd2);
    add_edges();
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph == 3);
      if (ph % 2 == 0) load_typical(2'($urandom_range(0, 3)));
      else load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
      random_phase(140);
    end
    quiet = 0;
    $display("covered %0d transactions over %0d calibration sets, %0d with divide faults",
             n_items, n_phases, n_faults);
    $display("%0d results checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
